### rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared command codes and controller/datapath interface types for the
// double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    // Width of the value ports.
    localparam int VALUE_W = 32;

    // Command codes on the input channel.
    localparam int CMD_W = 3;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;
    localparam logic [CMD_W-1:0] CMD_PEEK       = 3'd5;

    // Controller -> datapath commands.
    typedef struct packed {
        logic capture;   // latch the incoming item
        logic exec;      // update pointers, write the ring
        logic rd;        // read front and back slots
        logic load;      // load the output register
    } t_deq_ctl;

    // Datapath -> controller status.
    typedef struct packed {
        logic out_free;  // output register empty or being taken this cycle
    } t_deq_sts;

endpackage

### rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed words kept in a ring buffer.
// ----------------------------------------------------------------------------
// Each input item carries a command (push front, push back, pop front,
// pop back, clear, peek; codes 6 and 7 act as peek) and a value used only
// by the pushes. Every item returns exactly one result: front and back
// values after the command (zero when empty), the element count, empty and
// full flags, and a rejected flag for a push onto a full queue or a pop
// from an empty one, which leave the queue unchanged. An item passes four
// steps in order: capture at the accepting edge, pointer update with the
// ring write, a registered two-port read of the front and back slots, and
// the output load. The controller handles one item at a time, so the input
// takes no new item until the last one is loaded; a stalled result delays
// the load and thus the next acceptance by the stall length. The output
// register holds one finished result, so the next item is taken in while
// the last result still waits. Stored words are DATA_WIDTH bits, taken from
// the low bits of the value, and come back sign-extended (or cut) to 32
// bits. The storage needs no clearing after reset: only live slots are ever
// reported.
// ----------------------------------------------------------------------------
module double_ended_queue #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input channel
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [2:0]              i_command,
    input  logic signed [31:0]      i_value,
    // result channel
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [31:0]      o_front_value,
    output logic signed [31:0]      o_back_value,
    output logic [$clog2(DEPTH+1)-1:0] o_count,
    output logic                    o_is_empty,
    output logic                    o_is_full,
    output logic                    o_rejected
);
    import deq_pkg::*;

    t_deq_ctl ctl;
    t_deq_sts sts;

    // Sequencer: one item in flight, issues the datapath steps in order.
    deq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    // Ring memory, pointers and the output register.
    deq_dpath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .o_sts         (sts),
        .i_command     (i_command),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_front_value (o_front_value),
        .o_back_value  (o_back_value),
        .o_count       (o_count),
        .o_is_empty    (o_is_empty),
        .o_is_full     (o_is_full),
        .o_rejected    (o_rejected)
    );

endmodule

### rtl/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer: capture, execute, read, load output.
// ----------------------------------------------------------------------------
module deq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  deq_pkg::t_deq_sts i_sts,
    output deq_pkg::t_deq_ctl o_ctl
);
    import deq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_READ = 4'b0100,
        S_LOAD = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_ctl.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_ctl.exec = 1'b1;
                n_state    = S_READ;
            end
            S_READ: begin
                o_ctl.rd = 1'b1;
                n_state  = S_LOAD;
            end
            S_LOAD: begin
                if (i_sts.out_free) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

### rtl/deq_dpath.sv
// ----------------------------------------------------------------------------
// deq_dpath
// Ring buffer storage, front pointer, element count and output register.
// ----------------------------------------------------------------------------
module deq_dpath #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int CW         = $clog2(DEPTH + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  deq_pkg::t_deq_ctl              i_ctl,
    output deq_pkg::t_deq_sts              o_sts,
    input  logic [deq_pkg::CMD_W-1:0]      i_command,
    input  logic signed [deq_pkg::VALUE_W-1:0] i_value,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [deq_pkg::VALUE_W-1:0] o_front_value,
    output logic signed [deq_pkg::VALUE_W-1:0] o_back_value,
    output logic [CW-1:0]                  o_count,
    output logic                           o_is_empty,
    output logic                           o_is_full,
    output logic                           o_rejected
);
    import deq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int SW = AW + 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);

    function automatic logic signed [VALUE_W-1:0] widen(input logic signed [DATA_WIDTH-1:0] w);
        widen = VALUE_W'(w);
    endfunction

    function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
        wrap = (s >= DEPTH_S) ? AW'(s - DEPTH_S) : AW'(s);
    endfunction

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];

    logic [CMD_W-1:0]      r_cmd;
    logic [VALUE_W-1:0]    r_value;
    logic [AW-1:0]         r_front;
    logic [CW-1:0]         r_count;
    logic                  r_rej;
    logic [DATA_WIDTH-1:0] r_rd_front;
    logic [DATA_WIDTH-1:0] r_rd_back;

    logic [AW-1:0] n_front;
    logic [CW-1:0] n_count;
    logic          n_rej;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] back_addr;
    logic          full;
    logic          empty;

    logic                      r_out_valid;
    logic signed [VALUE_W-1:0] r_o_front;
    logic signed [VALUE_W-1:0] r_o_back;
    logic [CW-1:0]             r_o_count;
    logic                      r_o_empty;
    logic                      r_o_full;
    logic                      r_o_rej;

    assign full  = (r_count == FULL_CNT);
    assign empty = (r_count == '0);

    // Pointer and count update for the latched command.
    always_comb begin
        n_front = r_front;
        n_count = r_count;
        n_rej   = 1'b0;
        wr_en   = 1'b0;
        wr_addr = r_front;
        case (r_cmd)
            CMD_PUSH_FRONT: begin
                if (full) begin
                    n_rej = 1'b1;
                end else begin
                    n_front = (r_front == '0) ? LAST_IDX : r_front - 1'b1;
                    wr_addr = n_front;
                    wr_en   = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            CMD_PUSH_BACK: begin
                if (full) begin
                    n_rej = 1'b1;
                end else begin
                    wr_addr = wrap(SW'(r_front) + SW'(r_count));
                    wr_en   = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            CMD_POP_FRONT: begin
                if (empty) begin
                    n_rej = 1'b1;
                end else begin
                    n_front = (r_front == LAST_IDX) ? '0 : r_front + 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
            CMD_POP_BACK: begin
                if (empty) begin
                    n_rej = 1'b1;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            CMD_CLEAR: begin
                n_front = '0;
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    // Back slot: front + count - 1, wrapped; unused when empty.
    assign back_addr = empty ? r_front : wrap(SW'(r_front) + SW'(r_count) - 1'b1);

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd   <= i_command;
            r_value <= i_value;
        end
        if (i_ctl.exec) begin
            r_rej <= n_rej;
        end
        if (i_ctl.exec && wr_en) begin
            r_mem[wr_addr] <= DATA_WIDTH'(r_value);
        end
        if (i_ctl.rd) begin
            r_rd_front <= r_mem[r_front];
            r_rd_back  <= r_mem[back_addr];
        end
        if (i_ctl.load) begin
            r_o_front <= empty ? '0 : widen(r_rd_front);
            r_o_back  <= empty ? '0 : widen(r_rd_back);
            r_o_count <= r_count;
            r_o_empty <= empty;
            r_o_full  <= full;
            r_o_rej   <= r_rej;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.exec) begin
                r_front <= n_front;
                r_count <= n_count;
            end
            if (i_ctl.load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free = !r_out_valid || !i_stall;

    assign o_valid       = r_out_valid;
    assign o_front_value = r_o_front;
    assign o_back_value  = r_o_back;
    assign o_count       = r_o_count;
    assign o_is_empty    = r_o_empty;
    assign o_is_full     = r_o_full;
    assign o_rejected    = r_o_rej;

endmodule

### rtl/deq_chk.sv
// ----------------------------------------------------------------------------
// deq_chk
// Port-level checks for the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
module deq_chk #(
    parameter int DEPTH = 16
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic signed [31:0]          o_front_value,
    input logic signed [31:0]          o_back_value,
    input logic [$clog2(DEPTH+1)-1:0]  o_count,
    input logic                        o_is_empty,
    input logic                        o_is_full,
    input logic                        o_rejected
);
    localparam int CW = $clog2(DEPTH + 1);

    // A waiting result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_front_value)
            && $stable(o_back_value) && $stable(o_count) && $stable(o_rejected))
        else $error("result changed while stalled");

    // One item in flight: busy right after an accept.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after accept");

    // Empty flag tracks count, and an empty queue shows zero values.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_empty == (o_count == '0))
            && (!o_is_empty || (o_front_value == '0 && o_back_value == '0)))
        else $error("empty flag or empty values wrong");

    // Full flag tracks count, and count never exceeds the depth.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_full == (o_count == CW'(DEPTH))) && (o_count <= CW'(DEPTH)))
        else $error("full flag or count out of range");

endmodule

bind double_ended_queue deq_chk #(.DEPTH(DEPTH)) u_deq_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_front_value (o_front_value),
    .o_back_value  (o_back_value),
    .o_count       (o_count),
    .o_is_empty    (o_is_empty),
    .o_is_full     (o_is_full),
    .o_rejected    (o_rejected)
);
